FILE: hw/rtl/gbst_pkg.sv
`timescale 1ns / 1ps

package gbst_pkg;

    localparam int INDEX_W  = 6;
    localparam int AXIS_W   = 16;
    localparam int HAT_W    = 4;
    localparam int THRESH_W = 15;
    localparam int FUNC_W   = 3;
    localparam int HAT_DIRS  = 4;
    localparam int AXIS_DIRS = 2;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [FUNC_W-1:0] FUNC_BUTTON = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_AXIS   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_HAT    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FRAME  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd4;

    localparam logic [1:0] REG_AXIS_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_HAT_VIRT_EN    = 2'd1;
    localparam logic [1:0] REG_AXIS_VIRT_EN   = 2'd2;

    typedef struct packed {
        logic [THRESH_W-1:0] axis_threshold;
        logic                hat_virtual_enable;
        logic                axis_virtual_enable;
    } t_cfg;

    typedef struct packed {
        logic load_in;
        logic commit;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

FILE: hw/rtl/gamepad_button_state_tracker.sv
`timescale 1ns / 1ps

// Gamepad button state tracker. Each request on the input stream is one event
// (button, axis, hat, new frame or read) and yields exactly one result with
// the flags of the addressed button, the stored axis and hat values and a bad
// index flag. An item passes through capture, flag update and report: the
// request is captured at the accepting edge, the flags are updated at the
// next edge and the result register is loaded in the report state. The
// report waits while the result register still holds an untaken result,
// and a new request is accepted only after the previous result has been
// loaded. Buttons are numbered physical first, then four per hat (up, right,
// down, left), then two per axis (plus, minus). Configuration registers sit
// at byte addresses 0 (axis threshold), 4 (hat virtual enable) and 8 (axis
// virtual enable); write them only while the block is idle (not enforced).
module gamepad_button_state_tracker #(
    parameter int PHYS_BUTTONS = 16,
    parameter int AXIS_COUNT   = 8,
    parameter int HAT_COUNT    = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // index[5:0], release_req[6], axis_value[22:7], hat_value[26:23], zero
    input  logic [gbst_pkg::S_TDATA_W-1:0]      s_tdata,
    // func[2:0]
    input  logic [gbst_pkg::FUNC_W-1:0]         s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // is_down[0], is_up[1], is_pressed[2], is_released[3],
    // stored_axis[19:4], stored_hat[23:20]
    output logic [gbst_pkg::M_TDATA_W-1:0]      m_tdata,
    // bad_index[0]
    output logic [0:0]                          m_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gbst_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [gbst_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [gbst_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    gbst_pkg::t_cfg       w_cfg;
    gbst_pkg::t_ctrl_cmd  w_cmd;
    gbst_pkg::t_dp_status w_status;
    logic                 w_bad;

    gbst_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    gbst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    gbst_datapath #(
        .PHYS_BUTTONS (PHYS_BUTTONS),
        .AXIS_COUNT   (AXIS_COUNT),
        .HAT_COUNT    (HAT_COUNT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg         (w_cfg),
        .i_func        (s_tuser),
        .i_index       (s_tdata[5:0]),
        .i_release_req (s_tdata[6]),
        .i_axis_value  (s_tdata[22:7]),
        .i_hat_value   (s_tdata[26:23]),
        .o_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .o_m_tdata     (m_tdata),
        .o_m_tuser     (w_bad)
    );

    assign m_tuser[0] = w_bad;

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load_in, w_cmd.commit, w_cmd.load_out}))
        else $error("more than one command at once");

    a_commit_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_in |=> w_cmd.commit)
        else $error("accepted request not committed next cycle");

    a_report_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> m_tvalid)
        else $error("report did not raise result valid");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one in flight");

endmodule

FILE: hw/rtl/gbst_apb_regs.sv
`timescale 1ns / 1ps

module gbst_apb_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gbst_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [gbst_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [gbst_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output gbst_pkg::t_cfg                      o_cfg
);

    gbst_pkg::t_cfg r_cfg;
    logic           w_wr;
    logic [1:0]     w_reg;

    assign pready = 1'b1;
    assign w_reg  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (w_reg)
                gbst_pkg::REG_AXIS_THRESHOLD: begin
                    r_cfg.axis_threshold <= pwdata[gbst_pkg::THRESH_W-1:0];
                end
                gbst_pkg::REG_HAT_VIRT_EN: begin
                    r_cfg.hat_virtual_enable <= pwdata[0];
                end
                gbst_pkg::REG_AXIS_VIRT_EN: begin
                    r_cfg.axis_virtual_enable <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_reg)
            gbst_pkg::REG_AXIS_THRESHOLD: begin
                prdata[gbst_pkg::THRESH_W-1:0] = r_cfg.axis_threshold;
            end
            gbst_pkg::REG_HAT_VIRT_EN: begin
                prdata[0] = r_cfg.hat_virtual_enable;
            end
            gbst_pkg::REG_AXIS_VIRT_EN: begin
                prdata[0] = r_cfg.axis_virtual_enable;
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/gbst_ctrl.sv
`timescale 1ns / 1ps

module gbst_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  gbst_pkg::t_dp_status   i_status,
    output gbst_pkg::t_ctrl_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_UPDATE = 3'b010,
        S_REPORT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.commit = 1'b1;
                n_state      = S_REPORT;
            end
            S_REPORT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/gbst_datapath.sv
`timescale 1ns / 1ps

module gbst_datapath #(
    parameter int PHYS_BUTTONS = 16,
    parameter int AXIS_COUNT   = 8,
    parameter int HAT_COUNT    = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gbst_pkg::t_ctrl_cmd                 i_cmd,
    output gbst_pkg::t_dp_status                o_status,
    input  gbst_pkg::t_cfg                      i_cfg,
    input  logic [gbst_pkg::FUNC_W-1:0]         i_func,
    input  logic [gbst_pkg::INDEX_W-1:0]        i_index,
    input  logic                                i_release_req,
    input  logic signed [gbst_pkg::AXIS_W-1:0]  i_axis_value,
    input  logic [gbst_pkg::HAT_W-1:0]          i_hat_value,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [gbst_pkg::M_TDATA_W-1:0]      o_m_tdata,
    output logic                                o_m_tuser
);

    localparam int HAT_BASE    = PHYS_BUTTONS;
    localparam int AXIS_BASE   = PHYS_BUTTONS + gbst_pkg::HAT_DIRS * HAT_COUNT;
    localparam int TOTAL       = AXIS_BASE + gbst_pkg::AXIS_DIRS * AXIS_COUNT;
    localparam int TOTAL_DEPTH = (TOTAL > 0) ? TOTAL : 1;
    localparam int AXIS_DEPTH  = (AXIS_COUNT > 0) ? AXIS_COUNT : 1;
    localparam int HAT_DEPTH   = (HAT_COUNT > 0) ? HAT_COUNT : 1;

    logic [gbst_pkg::FUNC_W-1:0]         r_func;
    logic [gbst_pkg::INDEX_W-1:0]        r_index;
    logic                                r_release_req;
    logic signed [gbst_pkg::AXIS_W-1:0]  r_axis_value;
    logic [gbst_pkg::HAT_W-1:0]          r_hat_value;

    logic [TOTAL_DEPTH-1:0] r_down;
    logic [TOTAL_DEPTH-1:0] r_up;
    logic [TOTAL_DEPTH-1:0] r_pressed;
    logic [TOTAL_DEPTH-1:0] r_released;
    logic [TOTAL_DEPTH-1:0] n_down;
    logic [TOTAL_DEPTH-1:0] n_up;
    logic [TOTAL_DEPTH-1:0] n_pressed;
    logic [TOTAL_DEPTH-1:0] n_released;

    logic [gbst_pkg::AXIS_W-1:0] r_axis_vals [AXIS_DEPTH];
    logic [gbst_pkg::HAT_W-1:0]  r_hat_vals  [HAT_DEPTH];

    logic                           r_out_valid;
    logic [gbst_pkg::M_TDATA_W-1:0] r_out_tdata;
    logic                           r_out_bad;

    logic                        w_btn_ok;
    logic                        w_axis_ok;
    logic                        w_hat_ok;
    logic [gbst_pkg::AXIS_W-1:0] w_mag;
    logic                        w_above;
    logic                        w_positive;

    logic                        w_rd_down;
    logic                        w_rd_up;
    logic                        w_rd_pressed;
    logic                        w_rd_released;
    logic [gbst_pkg::AXIS_W-1:0] w_rd_axis;
    logic [gbst_pkg::HAT_W-1:0]  w_rd_hat;
    logic                        w_bad;

    assign w_btn_ok  = int'(r_index) < TOTAL;
    assign w_axis_ok = int'(r_index) < AXIS_COUNT;
    assign w_hat_ok  = int'(r_index) < HAT_COUNT;

    assign w_mag      = r_axis_value[gbst_pkg::AXIS_W-1] ?
                        (~r_axis_value + 16'd1) : r_axis_value;
    assign w_above    = w_mag > {1'b0, i_cfg.axis_threshold};
    assign w_positive = !r_axis_value[gbst_pkg::AXIS_W-1] && (|r_axis_value);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func        <= i_func;
            r_index       <= i_index;
            r_release_req <= i_release_req;
            r_axis_value  <= i_axis_value;
            r_hat_value   <= i_hat_value;
        end
    end

    always_comb begin
        int k;
        logic hit;
        n_down     = r_down;
        n_up       = r_up;
        n_pressed  = r_pressed;
        n_released = r_released;
        for (int b = 0; b < TOTAL_DEPTH; b++) begin
            k   = 0;
            hit = 1'b0;
            if (b < TOTAL) begin
                if (r_func == gbst_pkg::FUNC_BUTTON && int'(r_index) == b) begin
                    if (!r_release_req) begin
                        n_down[b]     = 1'b1;
                        n_pressed[b]  = 1'b1;
                        n_released[b] = 1'b0;
                    end else begin
                        n_up[b]       = 1'b1;
                        n_released[b] = 1'b1;
                        n_pressed[b]  = 1'b0;
                    end
                end
                if (r_func == gbst_pkg::FUNC_AXIS && i_cfg.axis_virtual_enable &&
                    w_axis_ok && b >= AXIS_BASE) begin
                    k = b - AXIS_BASE;
                    if ((k >> 1) == int'(r_index)) begin
                        if (w_above) begin
                            hit           = ((k & 1) == 0) ? w_positive : !w_positive;
                            n_down[b]     = hit;
                            n_pressed[b]  = hit;
                            n_released[b] = !hit;
                        end else begin
                            if (r_pressed[b]) begin
                                n_released[b] = 1'b1;
                                n_up[b]       = 1'b1;
                            end
                            n_pressed[b] = 1'b0;
                        end
                    end
                end
                if (r_func == gbst_pkg::FUNC_HAT && i_cfg.hat_virtual_enable &&
                    w_hat_ok && b >= HAT_BASE && b < AXIS_BASE) begin
                    k = b - HAT_BASE;
                    if ((k >> 2) == int'(r_index)) begin
                        if (r_hat_value == '0) begin
                            if (r_pressed[b]) begin
                                n_released[b] = 1'b1;
                                n_up[b]       = 1'b1;
                            end
                            n_pressed[b] = 1'b0;
                        end else begin
                            hit           = r_hat_value[k & 3];
                            n_down[b]     = hit;
                            n_pressed[b]  = hit;
                            n_released[b] = !hit;
                        end
                    end
                end
                if (r_func == gbst_pkg::FUNC_FRAME) begin
                    n_down[b] = 1'b0;
                    n_up[b]   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down     <= '0;
            r_up       <= '0;
            r_pressed  <= '0;
            r_released <= '1;
            for (int a = 0; a < AXIS_DEPTH; a++) begin
                r_axis_vals[a] <= '0;
            end
            for (int h = 0; h < HAT_DEPTH; h++) begin
                r_hat_vals[h] <= '0;
            end
        end else if (i_cmd.commit) begin
            r_down     <= n_down;
            r_up       <= n_up;
            r_pressed  <= n_pressed;
            r_released <= n_released;
            for (int a = 0; a < AXIS_DEPTH; a++) begin
                if (r_func == gbst_pkg::FUNC_AXIS && w_axis_ok && int'(r_index) == a) begin
                    r_axis_vals[a] <= r_axis_value;
                end
            end
            for (int h = 0; h < HAT_DEPTH; h++) begin
                if (r_func == gbst_pkg::FUNC_HAT && w_hat_ok && int'(r_index) == h) begin
                    r_hat_vals[h] <= r_hat_value;
                end
            end
        end
    end

    always_comb begin
        w_rd_down     = 1'b0;
        w_rd_up       = 1'b0;
        w_rd_pressed  = 1'b0;
        w_rd_released = 1'b0;
        w_rd_axis     = '0;
        w_rd_hat      = '0;
        for (int b = 0; b < TOTAL_DEPTH; b++) begin
            if (b < TOTAL && int'(r_index) == b) begin
                w_rd_down     = r_down[b];
                w_rd_up       = r_up[b];
                w_rd_pressed  = r_pressed[b];
                w_rd_released = r_released[b];
            end
        end
        for (int a = 0; a < AXIS_DEPTH; a++) begin
            if (a < AXIS_COUNT && int'(r_index) == a) begin
                w_rd_axis = r_axis_vals[a];
            end
        end
        for (int h = 0; h < HAT_DEPTH; h++) begin
            if (h < HAT_COUNT && int'(r_index) == h) begin
                w_rd_hat = r_hat_vals[h];
            end
        end
    end

    always_comb begin
        case (r_func)
            gbst_pkg::FUNC_BUTTON: w_bad = !w_btn_ok;
            gbst_pkg::FUNC_AXIS:   w_bad = !w_axis_ok;
            gbst_pkg::FUNC_HAT:    w_bad = !w_hat_ok;
            gbst_pkg::FUNC_READ:   w_bad = !w_btn_ok;
            default:               w_bad = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_tdata <= {w_rd_hat, w_rd_axis, w_rd_released, w_rd_pressed,
                            w_rd_up, w_rd_down};
            r_out_bad   <= w_bad;
        end
    end

    assign o_status.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid        = r_out_valid;
    assign o_m_tdata         = r_out_tdata;
    assign o_m_tuser         = r_out_bad;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import gbst_pkg::*;

    localparam int PHYS        = 16;
    localparam int AXES        = 8;
    localparam int HATS        = 4;
    localparam int HAT_BASE    = PHYS;
    localparam int AXIS_BASE   = PHYS + HAT_DIRS * HATS;
    localparam int NUM_BUTTONS = AXIS_BASE + AXIS_DIRS * AXES;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int PHASES         = 8;
    localparam int PHASE_EVENTS   = 215;

    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

    typedef enum logic {ROW_EVENT, ROW_REG} row_kind_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [INDEX_W-1:0] index;
        logic               release_req;
        logic [AXIS_W-1:0]  axis_value;
        logic [HAT_W-1:0]   hat_value;
    } pad_event_t;

    typedef struct packed {
        logic              bad_index;
        logic [HAT_W-1:0]  stored_hat;
        logic [AXIS_W-1:0] stored_axis;
        logic              is_released;
        logic              is_pressed;
        logic              is_up;
        logic              is_down;
    } btn_report_t;

    typedef struct {
        row_kind_t     kind;
        pad_event_t    ev;
        logic [1:0]    reg_id;
        logic [14:0]   reg_val;
        logic          fixed;
        btn_report_t   want;
    } plan_row_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [FUNC_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [0:0]             m_tuser;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    gamepad_button_state_tracker #(
        .PHYS_BUTTONS (PHYS),
        .AXIS_COUNT   (AXES),
        .HAT_COUNT    (HATS)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    logic              btn_down     [NUM_BUTTONS];
    logic              btn_up       [NUM_BUTTONS];
    logic              btn_pressed  [NUM_BUTTONS];
    logic              btn_released [NUM_BUTTONS];
    logic [AXIS_W-1:0] axis_mem     [AXES];
    logic [HAT_W-1:0]  hat_mem      [HATS];
    t_cfg              cfg;

    btn_report_t pending_reports[$];
    plan_row_t   plan[$];
    int          errors = 0;
    int          results_seen = 0;
    int          quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void press_btn(int b);
        btn_down[b]     = 1'b1;
        btn_pressed[b]  = 1'b1;
        btn_released[b] = 1'b0;
    endfunction

    function automatic void clear_btns(int base, int n);
        for (int i = 0; i < n; i++) begin
            btn_down[base + i]     = 1'b0;
            btn_pressed[base + i]  = 1'b0;
            btn_released[base + i] = 1'b1;
        end
    endfunction

    function automatic void release_btns(int base, int n);
        for (int i = 0; i < n; i++) begin
            if (btn_pressed[base + i]) begin
                btn_released[base + i] = 1'b1;
                btn_up[base + i]       = 1'b1;
            end
            btn_pressed[base + i] = 1'b0;
        end
    endfunction

    function automatic btn_report_t apply_event(pad_event_t ev);
        btn_report_t r;
        int          idx;
        int          base;
        int          val;
        int          mag;
        r   = '0;
        idx = ev.index;
        case (ev.func)
            FUNC_BUTTON: begin
                if (idx < NUM_BUTTONS) begin
                    if (!ev.release_req) begin
                        press_btn(idx);
                    end else begin
                        btn_up[idx]       = 1'b1;
                        btn_released[idx] = 1'b1;
                        btn_pressed[idx]  = 1'b0;
                    end
                end else begin
                    r.bad_index = 1'b1;
                end
            end
            FUNC_AXIS: begin
                if (idx < AXES) begin
                    val  = int'($signed(ev.axis_value));
                    mag  = (val < 0) ? -val : val;
                    base = AXIS_BASE + AXIS_DIRS * idx;
                    axis_mem[idx] = ev.axis_value;
                    if (cfg.axis_virtual_enable) begin
                        if (mag > int'(cfg.axis_threshold)) begin
                            clear_btns(base, AXIS_DIRS);
                            press_btn((val > 0) ? base : base + 1);
                        end else begin
                            release_btns(base, AXIS_DIRS);
                        end
                    end
                end else begin
                    r.bad_index = 1'b1;
                end
            end
            FUNC_HAT: begin
                if (idx < HATS) begin
                    base = HAT_BASE + HAT_DIRS * idx;
                    hat_mem[idx] = ev.hat_value;
                    if (cfg.hat_virtual_enable) begin
                        if (ev.hat_value == '0) begin
                            release_btns(base, HAT_DIRS);
                        end else begin
                            clear_btns(base, HAT_DIRS);
                            for (int d = 0; d < HAT_DIRS; d++) begin
                                if (ev.hat_value[d]) press_btn(base + d);
                            end
                        end
                    end
                end else begin
                    r.bad_index = 1'b1;
                end
            end
            FUNC_FRAME: begin
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    btn_down[i] = 1'b0;
                    btn_up[i]   = 1'b0;
                end
            end
            FUNC_READ: begin
                if (idx >= NUM_BUTTONS) r.bad_index = 1'b1;
            end
            default: ;
        endcase
        if (idx < NUM_BUTTONS) begin
            r.is_down     = btn_down[idx];
            r.is_up       = btn_up[idx];
            r.is_pressed  = btn_pressed[idx];
            r.is_released = btn_released[idx];
        end
        if (idx < AXES) r.stored_axis = axis_mem[idx];
        if (idx < HATS) r.stored_hat = hat_mem[idx];
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic plan_row_t event_row(logic [FUNC_W-1:0] func, logic [INDEX_W-1:0] index,
                                            logic rel, logic [AXIS_W-1:0] axis,
                                            logic [HAT_W-1:0] hat, logic fixed = 1'b0,
                                            btn_report_t want = '0);
        plan_row_t row;
        row.kind    = ROW_EVENT;
        row.ev      = '{func: func, index: index, release_req: rel, axis_value: axis,
                        hat_value: hat};
        row.reg_id  = '0;
        row.reg_val = '0;
        row.fixed   = fixed;
        row.want    = want;
        return row;
    endfunction

    function automatic plan_row_t reg_row(logic [1:0] reg_id, logic [14:0] reg_val);
        plan_row_t row;
        row         = event_row(FUNC_READ, '0, 1'b0, '0, '0);
        row.kind    = ROW_REG;
        row.reg_id  = reg_id;
        row.reg_val = reg_val;
        return row;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_event(pad_event_t ev, int gap, logic fixed, btn_report_t want);
        btn_report_t predicted;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, ev.hat_value, ev.axis_value, ev.release_req, ev.index};
        s_tuser  <= ev.func;
        do @(posedge i_clk); while (!s_tready);
        predicted = apply_event(ev);
        pending_reports.push_back(fixed ? want : predicted);
    endtask

    task automatic write_reg(logic [1:0] reg_id, logic [14:0] reg_val);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        paddr   <= {reg_id, 2'b00};
        pwdata  <= APB_DATA_W'(reg_val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (reg_id)
            REG_AXIS_THRESHOLD: cfg.axis_threshold      = reg_val;
            REG_HAT_VIRT_EN:    cfg.hat_virtual_enable  = reg_val[0];
            REG_AXIS_VIRT_EN:   cfg.axis_virtual_enable = reg_val[0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        btn_report_t got;
        btn_report_t want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata};
            results_seen++;
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                check_field("is_down", want.is_down, got.is_down);
                check_field("is_up", want.is_up, got.is_up);
                check_field("is_pressed", want.is_pressed, got.is_pressed);
                check_field("is_released", want.is_released, got.is_released);
                check_field("stored_axis", want.stored_axis, got.stored_axis);
                check_field("stored_hat", want.stored_hat, got.stored_hat);
                check_field("bad_index", want.bad_index, got.bad_index);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (i_rst_n) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("[gamepad_button_state_tracker] ERROR");
                $finish;
            end
        end
    end

    // Hold off once for a long stretch so the block backs up into its input.
    initial begin
        bit held_once;
        int gap;
        held_once = 1'b0;
        m_tready  = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!held_once && results_seen >= 300) begin
                held_once = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            repeat (($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40)) @(posedge i_clk);
            gap = idle_len();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin
        pad_event_t  ev;
        logic [14:0] thr;
        int          lim;
        int          a;
        int          r;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b1;
        paddr    = '0;
        pwdata   = '0;
        cfg      = '0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            btn_down[i]     = 1'b0;
            btn_up[i]       = 1'b0;
            btn_pressed[i]  = 1'b0;
            btn_released[i] = 1'b1;
        end
        for (int i = 0; i < AXES; i++) axis_mem[i] = '0;
        for (int i = 0; i < HATS; i++) hat_mem[i] = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fixed reports: {bad_index, hat, axis, released, pressed, up, down}
        plan.push_back(event_row(FUNC_READ, 6'd0, 1'b0, 16'h0000, 4'h0, 1'b1,
                                 {1'b0, 4'h0, 16'h0000, 4'b1000}));
        plan.push_back(event_row(FUNC_READ, 6'd63, 1'b0, 16'h0000, 4'h0, 1'b1,
                                 {1'b1, 4'h0, 16'h0000, 4'b0000}));
        plan.push_back(event_row(FUNC_BUTTON, 6'd47, 1'b0, 16'h0000, 4'h0, 1'b1,
                                 {1'b0, 4'h0, 16'h0000, 4'b0101}));
        plan.push_back(event_row(FUNC_BUTTON, 6'd48, 1'b1, 16'h0000, 4'h0, 1'b1,
                                 {1'b1, 4'h0, 16'h0000, 4'b0000}));
        plan.push_back(event_row(FUNC_AXIS, 6'd7, 1'b0, 16'h8000, 4'h0, 1'b1,
                                 {1'b0, 4'h0, 16'h8000, 4'b1000}));
        plan.push_back(event_row(FUNC_AXIS, 6'd8, 1'b1, 16'h7FFF, 4'hF));
        plan.push_back(event_row(FUNC_HAT, 6'd3, 1'b0, 16'h0000, 4'hF));
        plan.push_back(event_row(FUNC_HAT, 6'd4, 1'b0, 16'hFFFF, 4'hF));
        plan.push_back(event_row(FUNC_BUTTON, 6'd47, 1'b1, 16'h0000, 4'h0));
        plan.push_back(event_row(FUNC_FRAME, 6'd47, 1'b0, 16'h0000, 4'h0));
        plan.push_back(event_row(FUNC_SPARE_LO, 6'd63, 1'b1, 16'hFFFF, 4'hF));
        plan.push_back(event_row(FUNC_SPARE_HI, 6'd0, 1'b0, 16'h0000, 4'h0));
        plan.push_back(reg_row(REG_HAT_VIRT_EN, 15'd1));
        plan.push_back(reg_row(REG_AXIS_VIRT_EN, 15'd1));
        plan.push_back(reg_row(REG_AXIS_THRESHOLD, 15'h7FFF));
        plan.push_back(event_row(FUNC_AXIS, 6'd0, 1'b0, 16'h7FFF, 4'h0));
        plan.push_back(event_row(FUNC_AXIS, 6'd1, 1'b0, 16'h8000, 4'h0));
        plan.push_back(event_row(FUNC_READ, 6'(AXIS_BASE + 3), 1'b0, 16'h0000, 4'h0));
        plan.push_back(reg_row(REG_AXIS_THRESHOLD, 15'd0));
        plan.push_back(event_row(FUNC_AXIS, 6'd2, 1'b0, 16'h0000, 4'h0));
        plan.push_back(event_row(FUNC_AXIS, 6'd2, 1'b0, 16'h0001, 4'h0));
        plan.push_back(event_row(FUNC_AXIS, 6'd2, 1'b0, 16'hFFFF, 4'h0));
        plan.push_back(event_row(FUNC_AXIS, 6'd2, 1'b0, 16'h0000, 4'h0));
        plan.push_back(event_row(FUNC_READ, 6'(AXIS_BASE + 4), 1'b0, 16'h0000, 4'h0));
        plan.push_back(event_row(FUNC_HAT, 6'd0, 1'b0, 16'h0000, 4'h5));
        plan.push_back(event_row(FUNC_HAT, 6'd0, 1'b0, 16'h0000, 4'hA));
        plan.push_back(event_row(FUNC_HAT, 6'd0, 1'b0, 16'h0000, 4'h0));
        plan.push_back(event_row(FUNC_READ, 6'(HAT_BASE + 1), 1'b0, 16'h0000, 4'h0));
        plan.push_back(event_row(FUNC_FRAME, 6'd0, 1'b0, 16'h0000, 4'h0));
        plan.push_back(event_row(FUNC_READ, 6'(HAT_BASE + 1), 1'b0, 16'h0000, 4'h0));

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                write_reg(plan[i].reg_id, plan[i].reg_val);
            end else begin
                send_event(plan[i].ev, idle_len(), plan[i].fixed, plan[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) begin
                thr = '0;
            end else if (ph == 1) begin
                thr = 15'h7FFF;
            end else if ($urandom_range(0, 3) == 0) begin
                thr = 15'($urandom);
            end else begin
                thr = 15'($urandom_range(0, 3000));
            end
            write_reg(REG_AXIS_THRESHOLD, thr);
            write_reg(REG_HAT_VIRT_EN, (ph == 2) ? 15'd0 : 15'($urandom_range(0, 3) != 0));
            write_reg(REG_AXIS_VIRT_EN, (ph == 5) ? 15'd0 : 15'($urandom_range(0, 3) != 0));
            for (int n = 0; n < PHASE_EVENTS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 25) ev.func = FUNC_BUTTON;
                else if (r < 45) ev.func = FUNC_AXIS;
                else if (r < 65) ev.func = FUNC_HAT;
                else if (r < 70) ev.func = FUNC_FRAME;
                else if (r < 95) ev.func = FUNC_READ;
                else ev.func = FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
                lim = (ev.func == FUNC_AXIS) ? AXES : (ev.func == FUNC_HAT) ? HATS : NUM_BUTTONS;
                if ($urandom_range(0, 9) < 7) ev.index = INDEX_W'($urandom_range(0, lim - 1));
                else ev.index = INDEX_W'($urandom_range(0, 63));
                ev.release_req = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 5))
                    0: ev.axis_value = 16'h8000;
                    1: ev.axis_value = 16'h7FFF;
                    2: ev.axis_value = 16'h0000;
                    3, 4: begin
                        a = int'(cfg.axis_threshold) + int'($urandom_range(0, 2)) - 1;
                        if ($urandom_range(0, 1) == 1) a = -a;
                        ev.axis_value = AXIS_W'(a);
                    end
                    default: ev.axis_value = AXIS_W'($urandom);
                endcase
                if ($urandom_range(0, 3) == 0) ev.hat_value = '0;
                else ev.hat_value = HAT_W'($urandom_range(0, 15));
                send_event(ev, (ph == 3) ? 0 : idle_len(), 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("[gamepad_button_state_tracker] OK");
        end else begin
            $display("[gamepad_button_state_tracker] ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/gbst_pkg.sv
hw/rtl/gbst_apb_regs.sv
hw/rtl/gbst_ctrl.sv
hw/rtl/gbst_datapath.sv
hw/rtl/gamepad_button_state_tracker.sv
tb/sv/tb.sv
